FILE: design/prs_pkg.sv
// Package: sizes, candidate record type and constrained-domination function.
`default_nettype none
package prs_pkg;
  localparam int POP_MAX   = 64;
  localparam int KEY_WIDTH = 32;
  localparam int KEY_W     = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
  localparam int IDX_W     = (POP_MAX > 1) ? $clog2(POP_MAX) : 1;
  localparam int CNT_W     = $clog2(POP_MAX + 1);
  localparam int RANK_W    = 7;

  typedef struct packed {
    logic              valid;
    logic              feas;
    logic [31:0]       viol;
    logic [KEY_W-1:0]  key1;
    logic [KEY_W-1:0]  key2;
    logic [15:0]       size;
    logic [RANK_W-1:0] rank;
  } cand_t;

  // a dominates b
  function automatic logic dominates(input cand_t a, input cand_t b);
    logic no_worse;
    logic better;
    no_worse = (a.key1 <= b.key1) && (a.key2 <= b.key2) && (a.size <= b.size);
    better   = (a.key1 < b.key1) || (a.key2 < b.key2) || (a.size < b.size);
    if (a.feas && !b.feas) dominates = 1'b1;
    else if (!a.feas && !b.feas) dominates = a.viol < b.viol;
    else if (!a.feas) dominates = 1'b0;
    else dominates = no_worse && better;
  endfunction
endpackage
`default_nettype wire

FILE: design/pareto_rank_sort.sv
// Top level: constrained non-dominated ranking over a ring of candidate cells.
// Usage:
//  - Input channel (in_valid/in_ready) takes one candidate per transfer. Slots fill
//    in load order; candidates beyond POP_MAX are dropped. in_last closes the set.
//  - Ranking: every cell keeps rank = 1 + highest rank among its dominators.
//    One round copies each candidate into a traveling register and rotates
//    those copies once around the ring, so every cell meets every
//    other candidate once. Rounds repeat until a round changes nothing.
//  - A round is a start step, the rotation and a check step; each round settles
//    at least one more front, so rounds <= deepest front.
//  - Results (out_valid/out_ready) then leave one per cycle while out_ready is high,
//    slot 0 first, from an output register; out_final_res marks the last loaded slot.
//  - in_ready is high only while loading; it returns as soon as the last
//    result sits in the output register.
//  - A stalled receiver holds the output register and pauses emission only.
//  - Reset (rst_n low, synchronous) empties the population and clears out_valid.
`default_nettype none
module pareto_rank_sort import prs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_feasible,
  input  wire logic [31:0] in_violation,
  input  wire logic [31:0] in_domain_error,
  input  wire logic [31:0] in_boundary_error,
  input  wire logic [15:0] in_node_count,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_slot,
  output logic [6:0]       out_rank,
  output logic             out_final_res
);
  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_START = 5'b00010,
    S_SWEEP = 5'b00100,
    S_CHECK = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;     // loaded candidates
  logic [IDX_W-1:0] swp_r, swp_nxt;     // rotation step / emit index
  logic             chg_r, chg_nxt;     // any rank moved this round
  logic             ov_r, ov_nxt;
  logic [5:0]       slot_r, slot_nxt;
  logic [6:0]       rank_r, rank_nxt;
  logic             fin_r, fin_nxt;

  cand_t             trav [POP_MAX];
  logic [RANK_W-1:0] ranks [POP_MAX];
  logic [POP_MAX-1:0] chg_vec;
  cand_t             ld;
  logic              in_xfer, start, sweep;

  assign in_xfer = in_valid && in_ready;
  assign start   = state_r == S_START;
  assign sweep   = state_r == S_SWEEP;

  always_comb begin
    ld = '0;
    ld.valid = 1'b1;
    ld.feas  = in_feasible;
    ld.viol  = in_violation;
    ld.key1  = in_domain_error[KEY_W-1:0];
    ld.key2  = in_boundary_error[KEY_W-1:0];
    ld.size  = in_node_count;
  end

  for (genvar k = 0; k < POP_MAX; k++) begin : g_cell
    prs_cell u_cell (
      .clk      (clk),
      .load_en  (in_xfer && (cnt_r == CNT_W'(k))),
      .load_data(ld),
      .own_valid(CNT_W'(k) < cnt_r),
      .start    (start),
      .sweep    (sweep),
      .trav_in  (trav[(k + POP_MAX - 1) % POP_MAX]),
      .trav_out (trav[k]),
      .rank     (ranks[k]),
      .changed  (chg_vec[k])
    );
  end

  assign in_ready      = state_r == S_LOAD;
  assign out_valid     = ov_r;
  assign out_slot      = slot_r;
  assign out_rank      = rank_r;
  assign out_final_res = fin_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    swp_nxt   = swp_r;
    chg_nxt   = chg_r;
    ov_nxt    = ov_r;
    slot_nxt  = slot_r;
    rank_nxt  = rank_r;
    fin_nxt   = fin_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          if (cnt_r < CNT_W'(POP_MAX)) cnt_nxt = cnt_r + CNT_W'(1);
          if (in_last) state_nxt = S_START;
        end
      end
      S_START: begin
        swp_nxt   = '0;
        chg_nxt   = 1'b0;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (|chg_vec) chg_nxt = 1'b1;
        swp_nxt = swp_r + IDX_W'(1);
        if (swp_r == IDX_W'(POP_MAX - 1)) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        swp_nxt   = '0;
        state_nxt = chg_r ? S_START : S_EMIT;
      end
      S_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt   = 1'b1;
          slot_nxt = 6'(swp_r);
          rank_nxt = 7'(ranks[swp_r]);
          fin_nxt  = (CNT_W'(swp_r) + CNT_W'(1)) == cnt_r;
          swp_nxt  = swp_r + IDX_W'(1);
          if ((CNT_W'(swp_r) + CNT_W'(1)) == cnt_r) begin
            cnt_nxt   = '0;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      swp_r   <= '0;
      chg_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      swp_r   <= swp_nxt;
      chg_r   <= chg_nxt;
      ov_r    <= ov_nxt;
    end
    slot_r <= slot_nxt;
    rank_r <= rank_nxt;
    fin_r  <= fin_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(POP_MAX)) else $error("population count overflow");
  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP && swp_r == IDX_W'(POP_MAX - 1)) |=> state_r == S_CHECK)
    else $error("rotation did not end after a full ring");
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> cnt_r != '0) else $error("emitting an empty population");
endmodule
`default_nettype wire

FILE: design/prs_cell.sv
// One ring cell: holds a candidate and a circulating copy, relaxes its rank.
`default_nettype none
module prs_cell import prs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  load_en,
  input  wire cand_t load_data,
  input  wire logic  own_valid,
  input  wire logic  start,
  input  wire logic  sweep,
  input  wire cand_t trav_in,
  output cand_t      trav_out,
  output logic [RANK_W-1:0] rank,
  output logic       changed
);
  cand_t own_r, own_nxt;
  cand_t trav_r, trav_nxt;
  logic [RANK_W-1:0] cand_rank;
  logic              hit;

  always_comb begin
    cand_rank = trav_r.rank + RANK_W'(1);
    hit = sweep && trav_r.valid && own_valid && dominates(trav_r, own_r)
          && (cand_rank > own_r.rank);
    own_nxt = own_r;
    if (load_en) begin
      own_nxt = load_data;
      own_nxt.rank = RANK_W'(1);
    end else if (hit) begin
      own_nxt.rank = cand_rank;
    end
    trav_nxt = trav_r;
    if (start) begin
      trav_nxt = own_r;
      trav_nxt.valid = own_valid;
    end else if (sweep) begin
      trav_nxt = trav_in;
    end
  end

  always_ff @(posedge clk) begin
    own_r  <= own_nxt;
    trav_r <= trav_nxt;
  end

  assign trav_out = trav_r;
  assign rank     = own_r.rank;
  assign changed  = hit;
endmodule
`default_nettype wire
